// File: rtl/page_frame_free_stack_unit_assert.svh
// Assertion macros for the free page stack unit.
// Needs clk and rst in the scope of each use.
`ifndef PAGE_FRAME_FREE_STACK_UNIT_ASSERT_SVH
`define PAGE_FRAME_FREE_STACK_UNIT_ASSERT_SVH

// same-cycle implication
`define PFFS_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PFFS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/pffs_pkg.sv
// Package for the free page stack unit: widths, codes, state type.
// No dependencies.
package pffs_pkg;

  localparam int COUNT_W  = 7;
  localparam int PAGE_W   = 32;
  localparam int CAP_W    = 13;
  localparam int STATUS_W = 2;

  localparam int DEPTH_DEFAULT   = 4096;
  localparam int MAX_RUN_DEFAULT = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 13'd4096;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK  = 2'd0,
    STAT_BAD = 2'd1,
    STAT_OOM = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_POP  = 1'b1
  } state_t;

endpackage

// File: rtl/pffs_if.sv
// Handshake channels of the free page stack unit: request, result, config.
// Depends on pffs_pkg.
interface pffs_req_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [pffs_pkg::COUNT_W-1:0]  count;
  logic [pffs_pkg::PAGE_W-1:0]   page;
  logic                          last;

  modport source (output valid, mode, count, page, last, input ready);
  modport sink   (input valid, mode, count, page, last, output ready);
endinterface

interface pffs_res_if;
  logic                          valid;
  logic                          ready;
  logic [pffs_pkg::STATUS_W-1:0] status;
  logic [pffs_pkg::PAGE_W-1:0]   page_res;
  logic                          last_res;

  modport source (output valid, status, page_res, last_res, input ready);
  modport sink   (input valid, status, page_res, last_res, output ready);
endinterface

interface pffs_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pffs_pkg::CAP_W-1:0]  capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface

// File: rtl/page_frame_free_stack_unit.sv
// Free page frame stack allocator, top level. Depends on pffs_pkg, pffs_if, pffs_ram
// and page_frame_free_stack_unit_assert.svh.
//
// Channels: req (sink) carries mode, count, page, last; res (source) carries status,
// page_res, last_res; cfg (sink) is always ready. The user writes capacity only while
// idle; the block does not enforce this. Allocate: one item in, count results out (or
// one error result). The first frame is read from the store and then loaded into the
// output register; further frames follow one per cycle while the receiver takes them.
// The single RAM port sets this rate.
// Free: each item pushes its frame in the cycle it is accepted, unless its run is
// rejected or the stack is at capacity; only the item with last gives a result.
// Errors give one result with page_res zero.
// Results go through an output register; req is ready only when the block is idle and
// that register is empty or being taken. A stalled receiver halts popping in place.
// Reset: fill level zero, no run open, capacity 4096. Stack contents are not cleared;
// only slots below the fill level are ever read.
module page_frame_free_stack_unit #(
  parameter int DEPTH   = pffs_pkg::DEPTH_DEFAULT,
  parameter int MAX_RUN = pffs_pkg::MAX_RUN_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  pffs_req_if.sink   req,
  pffs_res_if.source res,
  pffs_cfg_if.sink   cfg
);

  `include "page_frame_free_stack_unit_assert.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int FW = $clog2(DEPTH + 1);
  localparam int CW = (FW > pffs_pkg::CAP_W) ? FW : pffs_pkg::CAP_W;
  localparam int EW = CW + 1;

  pffs_pkg::state_t                state, state_next;
  logic [FW-1:0]                   fill_level, fill_level_next;
  logic                            in_run, in_run_next;
  logic                            run_rej, run_rej_next;
  logic [AW-1:0]                   ptr, ptr_next;
  logic [pffs_pkg::COUNT_W-1:0]    remaining, remaining_next;
  logic [pffs_pkg::CAP_W-1:0]      capacity;

  logic                            res_valid;
  pffs_pkg::status_t               res_status, res_status_next;
  logic [pffs_pkg::PAGE_W-1:0]     res_page, res_page_next;
  logic                            res_last, res_last_next;
  logic                            res_load;

  logic                            mem_en, mem_we;
  logic [AW-1:0]                   mem_addr;
  logic [pffs_pkg::PAGE_W-1:0]     mem_rdata;

  logic                            out_free, req_fire, push;
  logic [EW-1:0]                   cap_eff, fill_ext, cnt_ext, pop_base;
  logic                            cnt_bad, rej_now;

  assign out_free  = !res_valid || res.ready;
  assign req.ready = (state == pffs_pkg::S_IDLE) && out_free;
  assign req_fire  = req.valid && req.ready;
  assign cfg.ready = 1'b1;

  assign res.valid    = res_valid;
  assign res.status   = res_status;
  assign res.page_res = res_page;
  assign res.last_res = res_last;

  assign cap_eff  = (EW'(capacity) < EW'(DEPTH)) ? EW'(capacity) : EW'(DEPTH);
  assign fill_ext = EW'(fill_level);
  assign cnt_ext  = EW'(req.count);
  assign pop_base = fill_ext - cnt_ext;
  assign cnt_bad  = (req.count == '0) || (cnt_ext > EW'(MAX_RUN)) || (cnt_ext > cap_eff);
  assign rej_now  = in_run ? run_rej : (cnt_bad || (fill_ext + cnt_ext > cap_eff));

  always_comb begin
    state_next      = state;
    fill_level_next = fill_level;
    in_run_next     = in_run;
    run_rej_next    = run_rej;
    ptr_next        = ptr;
    remaining_next  = remaining;
    res_load        = 1'b0;
    res_status_next = pffs_pkg::STAT_OK;
    res_page_next   = '0;
    res_last_next   = 1'b1;
    mem_en          = 1'b0;
    mem_we          = 1'b0;
    mem_addr        = ptr;
    push            = 1'b0;
    case (state)
      pffs_pkg::S_IDLE: begin
        if (req_fire) begin
          if (req.mode == pffs_pkg::MODE_ALLOC) begin
            if (cnt_bad) begin
              res_load        = 1'b1;
              res_status_next = pffs_pkg::STAT_BAD;
            end else if (cnt_ext > fill_ext) begin
              res_load        = 1'b1;
              res_status_next = pffs_pkg::STAT_OOM;
            end else begin
              fill_level_next = FW'(pop_base);
              mem_en          = 1'b1;
              mem_addr        = AW'(pop_base);
              ptr_next        = AW'(pop_base) + AW'(1);
              remaining_next  = req.count;
              state_next      = pffs_pkg::S_POP;
            end
          end else begin
            push = !rej_now && (fill_ext < cap_eff);
            if (push) begin
              mem_en          = 1'b1;
              mem_we          = 1'b1;
              mem_addr        = AW'(fill_level);
              fill_level_next = fill_level + FW'(1);
            end
            if (req.last) begin
              res_load        = 1'b1;
              res_status_next = rej_now ? pffs_pkg::STAT_BAD : pffs_pkg::STAT_OK;
              in_run_next     = 1'b0;
              run_rej_next    = 1'b0;
            end else begin
              in_run_next  = 1'b1;
              run_rej_next = rej_now;
            end
          end
        end
      end
      pffs_pkg::S_POP: begin
        if (out_free) begin
          res_load      = 1'b1;
          res_page_next = mem_rdata;
          res_last_next = (remaining == pffs_pkg::COUNT_W'(1));
          if (remaining == pffs_pkg::COUNT_W'(1)) begin
            state_next = pffs_pkg::S_IDLE;
          end else begin
            mem_en         = 1'b1;
            mem_addr       = ptr;
            ptr_next       = ptr + AW'(1);
            remaining_next = remaining - pffs_pkg::COUNT_W'(1);
          end
        end
      end
      default: begin
        state_next = pffs_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pffs_pkg::S_IDLE;
      fill_level <= '0;
      in_run     <= 1'b0;
      run_rej    <= 1'b0;
      res_valid  <= 1'b0;
      capacity   <= pffs_pkg::CAP_RESET;
      remaining  <= '0;
    end else begin
      state      <= state_next;
      fill_level <= fill_level_next;
      in_run     <= in_run_next;
      run_rej    <= run_rej_next;
      remaining  <= remaining_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg.valid) begin
        capacity <= cfg.capacity;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (res_load) begin
      res_status <= res_status_next;
      res_page   <= res_page_next;
      res_last   <= res_last_next;
    end
  end

  pffs_ram #(
    .WIDTH (pffs_pkg::PAGE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (req.page),
    .rdata (mem_rdata)
  );

  `PFFS_CHECK(a_pop_nonempty, state == pffs_pkg::S_POP, remaining != '0, "pop with no frames left")
  `PFFS_CHECK(a_no_push_in_pop, state == pffs_pkg::S_POP, !mem_we, "store written while popping")
  `PFFS_CHECK(a_err_shape, res.valid && res.status != pffs_pkg::STAT_OK, res.page_res == '0 && res.last_res, "malformed error result")
  `PFFS_CHECK_NEXT(a_push_fill, push, fill_level == $past(fill_level) + FW'(1), "push did not raise fill level")
  `PFFS_CHECK(a_fill_bound, 1'b1, EW'(fill_level) <= EW'(DEPTH), "fill level beyond depth")

endmodule

// File: rtl/pffs_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module pffs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// File: bench/tb_top.sv
// Testbench for page_frame_free_stack_unit: directed and random alloc/free traffic.
// A local stack model predicts every result; a checker compares results in order.
// Depends on pffs_pkg, the pffs_if interfaces and the unit's RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam int STACK_DEPTH = pffs_pkg::DEPTH_DEFAULT;
  localparam int RUN_MAX     = pffs_pkg::MAX_RUN_DEFAULT;
  localparam int CNT_W       = pffs_pkg::COUNT_W;

  typedef struct packed {
    pffs_pkg::status_t           status;
    logic [pffs_pkg::PAGE_W-1:0] page;
    logic                        last;
  } page_result_t;

  logic clk;
  logic rst;

  pffs_req_if req_ch ();
  pffs_res_if res_ch ();
  pffs_cfg_if cfg_ch ();

  page_frame_free_stack_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // stack model
  logic [pffs_pkg::PAGE_W-1:0] frame_model [STACK_DEPTH];
  int                          fill_model;
  logic                        run_open;
  logic                        run_bad;
  int                          cap_model;

  page_result_t expected_results [$];
  int           mismatch_count;
  int           items_sent;
  logic         no_idle;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    res_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 19);
  end

  task automatic predict_stack_op(input pffs_pkg::mode_t mode, input logic [CNT_W-1:0] count,
                                  input logic [pffs_pkg::PAGE_W-1:0] page, input logic last);
    int cap;
    int n;
    cap = (cap_model < STACK_DEPTH) ? cap_model : STACK_DEPTH;
    n = int'(count);
    if (mode == pffs_pkg::MODE_ALLOC) begin
      if (n == 0 || n > RUN_MAX || n > cap) begin
        expected_results.push_back('{pffs_pkg::STAT_BAD, '0, 1'b1});
      end else if (n > fill_model) begin
        expected_results.push_back('{pffs_pkg::STAT_OOM, '0, 1'b1});
      end else begin
        fill_model -= n;
        for (int i = 0; i < n; i++) begin
          expected_results.push_back('{pffs_pkg::STAT_OK, frame_model[fill_model + i],
                                       i == n - 1});
        end
      end
    end else begin
      if (!run_open) begin
        run_open = 1'b1;
        run_bad = n == 0 || n > RUN_MAX || n > cap || fill_model + n > cap;
      end
      if (!run_bad && fill_model < cap) begin
        frame_model[fill_model] = page;
        fill_model++;
      end
      if (last) begin
        expected_results.push_back('{run_bad ? pffs_pkg::STAT_BAD : pffs_pkg::STAT_OK,
                                     '0, 1'b1});
        run_open = 1'b0;
        run_bad = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    page_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d page %h last %0b",
               res_ch.status, res_ch.page_res, res_ch.last_res);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_ch.status);
          mismatch_count++;
        end
        if (res_ch.page_res !== want.page) begin
          $error("page_res: expected %h, got %h", want.page, res_ch.page_res);
          mismatch_count++;
        end
        if (res_ch.last_res !== want.last) begin
          $error("last_res: expected %0b, got %0b", want.last, res_ch.last_res);
          mismatch_count++;
        end
      end
    end
  end

  // valid stays high between back-to-back items unless a random idle is inserted first
  task automatic send_item(input pffs_pkg::mode_t mode, input logic [CNT_W-1:0] count,
                           input logic [pffs_pkg::PAGE_W-1:0] page, input logic last);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 19) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.mode  = mode;
    req_ch.count = count;
    req_ch.page  = page;
    req_ch.last  = last;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    predict_stack_op(mode, count, page, last);
    items_sent++;
  endtask

  task automatic end_request_burst();
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  task automatic write_capacity(input logic [pffs_pkg::CAP_W-1:0] value);
    end_request_burst();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_ch.capacity = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    cap_model = int'(value);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic test_request_checks();
    send_item(pffs_pkg::MODE_ALLOC, 7'd1, $urandom, 1'b0);
    send_item(pffs_pkg::MODE_ALLOC, 7'd0, $urandom, 1'b1);
    send_item(pffs_pkg::MODE_ALLOC, 7'd64, $urandom, 1'b0);
    send_item(pffs_pkg::MODE_ALLOC, 7'd65, $urandom, 1'b1);
    send_item(pffs_pkg::MODE_ALLOC, 7'd127, $urandom, 1'b0);
  endtask

  task automatic test_free_runs();
    // alloc in the middle of a run
    send_item(pffs_pkg::MODE_FREE, 7'd3, 32'h0000_0000, 1'b0);
    send_item(pffs_pkg::MODE_ALLOC, 7'd1, $urandom, 1'b1);
    send_item(pffs_pkg::MODE_FREE, 7'd0, 32'hFFFF_FFFF, 1'b0);
    send_item(pffs_pkg::MODE_FREE, 7'd127, 32'h5A5A_5A5A, 1'b1);
    send_item(pffs_pkg::MODE_FREE, 7'd0, 32'hA5A5_A5A5, 1'b1);
    send_item(pffs_pkg::MODE_FREE, 7'd65, $urandom, 1'b0);
    send_item(pffs_pkg::MODE_FREE, 7'd1, $urandom, 1'b1);
    // shorter and longer than count
    send_item(pffs_pkg::MODE_FREE, 7'd4, 32'h8000_0001, 1'b1);
    send_item(pffs_pkg::MODE_FREE, 7'd1, 32'h7FFF_FFFE, 1'b0);
    send_item(pffs_pkg::MODE_FREE, 7'd64, 32'h1234_5678, 1'b0);
    send_item(pffs_pkg::MODE_FREE, 7'd2, 32'hDEAD_BEEF, 1'b1);
    send_item(pffs_pkg::MODE_ALLOC, 7'd6, $urandom, 1'b0);
    send_item(pffs_pkg::MODE_ALLOC, 7'd1, $urandom, 1'b0);
  endtask

  task automatic test_capacity_limits();
    write_capacity(13'd0);
    send_item(pffs_pkg::MODE_ALLOC, 7'd1, $urandom, 1'b0);
    send_item(pffs_pkg::MODE_FREE, 7'd1, $urandom, 1'b1);
    write_capacity(13'd2);
    send_item(pffs_pkg::MODE_FREE, 7'd2, $urandom, 1'b0);
    send_item(pffs_pkg::MODE_FREE, 7'd2, $urandom, 1'b0);
    send_item(pffs_pkg::MODE_FREE, 7'd2, $urandom, 1'b0);
    send_item(pffs_pkg::MODE_FREE, 7'd2, $urandom, 1'b1);
    // capacity now below fill level
    write_capacity(13'd1);
    send_item(pffs_pkg::MODE_ALLOC, 7'd2, $urandom, 1'b0);
    send_item(pffs_pkg::MODE_ALLOC, 7'd1, $urandom, 1'b0);
    send_item(pffs_pkg::MODE_FREE, 7'd1, $urandom, 1'b1);
    write_capacity(13'h1FFF);
    send_item(pffs_pkg::MODE_ALLOC, 7'd1, $urandom, 1'b1);
  endtask

  task automatic send_random_alloc();
    int top;
    top = fill_model < RUN_MAX ? fill_model : RUN_MAX;
    if (top > 0 && $urandom_range(99) < 75)
      send_item(pffs_pkg::MODE_ALLOC, CNT_W'($urandom_range(top, 1)), $urandom,
                1'($urandom_range(1)));
    else
      send_item(pffs_pkg::MODE_ALLOC, CNT_W'($urandom_range(127)), $urandom,
                1'($urandom_range(1)));
  endtask

  task automatic send_random_run();
    int count;
    int len;
    int pick;
    pick = $urandom_range(99);
    if (pick < 8)
      count = ($urandom_range(2) == 0) ? 0 : $urandom_range(127, 64);
    else if (pick < 20)
      count = $urandom_range(64, 13);
    else
      count = $urandom_range(12, 1);
    len = (count == 0 || count > RUN_MAX) ? $urandom_range(4, 1) : count;
    pick = $urandom_range(99);
    if (pick < 10)
      len = $urandom_range(len, 1);
    else if (pick < 20)
      len = len + $urandom_range(3, 1);
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(99) < 5) send_random_alloc();
      send_item(pffs_pkg::MODE_FREE,
                (i == 0) ? CNT_W'(count) : CNT_W'($urandom_range(127)),
                $urandom, i == len - 1);
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 55) send_random_run();
      else send_random_alloc();
    end
  endtask

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode = pffs_pkg::MODE_ALLOC;
    req_ch.count = '0;
    req_ch.page = '0;
    req_ch.last = 1'b0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.capacity = pffs_pkg::CAP_RESET;
    fill_model = 0;
    run_open = 1'b0;
    run_bad = 1'b0;
    cap_model = int'(pffs_pkg::CAP_RESET);
    mismatch_count = 0;
    items_sent = 0;
    no_idle = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_request_checks();
    test_free_runs();
    test_capacity_limits();

    test_random_traffic(40);
    write_capacity(13'd48);
    test_random_traffic(35);
    write_capacity(13'd20);
    test_random_traffic(25);
    write_capacity(13'd4096);
    no_idle = 1'b1;
    test_random_traffic(35);
    no_idle = 1'b0;
    write_capacity(13'd0);
    test_random_traffic(6);
    write_capacity(13'd64);
    test_random_traffic(20);

    end_request_burst();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
